/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/hsvf_pkg.sv */
// Package for the HSV to RGB565 fade pipeline: field widths, color constants,
// hue sector and channel selection types, and small helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsvf_pkg;

  localparam int unsigned HUE_W      = 15;
  localparam int unsigned IN_W       = 9;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned CH_W       = 6;
  localparam int unsigned R_W        = 5;
  localparam int unsigned B_W        = 5;
  localparam int unsigned QT_W       = 10;
  localparam int unsigned QM_W       = 15;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PIPE_DEPTH = 9;

  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_FULL   = 23040;
  localparam int unsigned SECTOR_POW = 8;
  localparam int unsigned SECTOR_ODD = 15;
  localparam int unsigned RECIP_MUL  = 17;
  localparam int unsigned RECIP_SHIFT = 8;

  localparam int unsigned R_MAX = 31;
  localparam int unsigned G_MAX = 63;
  localparam int unsigned B_MAX = 31;

  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_e;

  typedef enum logic [1:0] {
    PICK_C,
    PICK_X,
    PICK_Z
  } pick_e;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
  } stg_en_t;

  function automatic pick_e pick(sector_e sec, logic [1:0] ch);
    pick_e p;
    case (sec)
      SEC_RED_YEL: p = (ch == CH_R) ? PICK_C : ((ch == CH_G) ? PICK_X : PICK_Z);
      SEC_YEL_GRN: p = (ch == CH_R) ? PICK_X : ((ch == CH_G) ? PICK_C : PICK_Z);
      SEC_GRN_CYN: p = (ch == CH_R) ? PICK_Z : ((ch == CH_G) ? PICK_C : PICK_X);
      SEC_CYN_BLU: p = (ch == CH_R) ? PICK_Z : ((ch == CH_G) ? PICK_X : PICK_C);
      SEC_BLU_MAG: p = (ch == CH_R) ? PICK_X : ((ch == CH_G) ? PICK_Z : PICK_C);
      default:     p = (ch == CH_R) ? PICK_C : ((ch == CH_G) ? PICK_Z : PICK_X);
    endcase
    return p;
  endfunction

  function automatic logic [CH_W-1:0] ch_max(logic [1:0] ch);
    logic [CH_W-1:0] m;
    case (ch)
      CH_R:    m = CH_W'(R_MAX);
      CH_G:    m = CH_W'(G_MAX);
      default: m = CH_W'(B_MAX);
    endcase
    return m;
  endfunction

  function automatic logic [PIX_W-1:0] pack565(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                               logic [CH_W-1:0] b);
    return {r[R_W-1:0], g, b[B_W-1:0]};
  endfunction

endpackage

`default_nettype wire

/* rtl/hsvf_front.sv */
// Front stages: hue wrap and input clamp, sector and hue distance with v*s,
// then the chroma products. Depends on hsvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvf_front import hsvf_pkg::*; #(
  parameter int unsigned SCALE_BITS = 8
) (
  input  wire                                clk_i,
  input  stg_en_t                            en_i,
  input  wire  [HUE_W-1:0]                   hue_i,
  input  wire  [IN_W-1:0]                    saturation_i,
  input  wire  [IN_W-1:0]                    brightness_i,
  input  wire  [IN_W-1:0]                    fade_factor_i,
  output sector_e                            sector_o,
  output logic [2*IN_W+DIST_W-1:0]           px_o,
  output logic [2*IN_W+DIST_W-1:0]           pz_o,
  output logic [IN_W+SCALE_BITS+DIST_W-1:0]  vone_o,
  output logic [IN_W-1:0]                    factor_o
);

  localparam int unsigned ONE    = 1 << SCALE_BITS;
  localparam int unsigned VS_W   = 2 * IN_W;
  localparam int unsigned PROD_W = 2 * IN_W + DIST_W;
  localparam int unsigned VW     = IN_W + SCALE_BITS + DIST_W;

  logic [HUE_W-1:0]  hue_d, hue_q;
  logic [IN_W-1:0]   s_d, s_q, v_d, v_q, f1_q;
  sector_e           sector_d, sector_q, sector3_q;
  logic [HUE_W-1:0]  center;
  logic [DIST_W-1:0] dist_d, dist_q;
  logic [VS_W-1:0]   vs_d, vs_q;
  logic [IN_W-1:0]   v2_q, f2_q, f3_q;
  logic [PROD_W-1:0] px_d, px_q, pz_d, pz_q;
  logic [VW-1:0]     vone_d, vone_q;

  always_comb begin
    hue_d = (hue_i >= HUE_W'(HUE_FULL)) ? (hue_i - HUE_W'(HUE_FULL)) : hue_i;
    s_d   = (32'(saturation_i) > ONE) ? IN_W'(ONE) : saturation_i;
    v_d   = (32'(brightness_i) > ONE) ? IN_W'(ONE) : brightness_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      hue_q <= hue_d;
      s_q   <= s_d;
      v_q   <= v_d;
      f1_q  <= fade_factor_i;
    end
  end

  always_comb begin
    if (hue_q < HUE_W'(HUE_SECTOR)) begin
      sector_d = SEC_RED_YEL;
    end else if (hue_q < HUE_W'(2 * HUE_SECTOR)) begin
      sector_d = SEC_YEL_GRN;
    end else if (hue_q < HUE_W'(3 * HUE_SECTOR)) begin
      sector_d = SEC_GRN_CYN;
    end else if (hue_q < HUE_W'(4 * HUE_SECTOR)) begin
      sector_d = SEC_CYN_BLU;
    end else if (hue_q < HUE_W'(5 * HUE_SECTOR)) begin
      sector_d = SEC_BLU_MAG;
    end else begin
      sector_d = SEC_MAG_RED;
    end
    if (hue_q < HUE_W'(2 * HUE_SECTOR)) begin
      center = HUE_W'(HUE_SECTOR);
    end else if (hue_q < HUE_W'(4 * HUE_SECTOR)) begin
      center = HUE_W'(3 * HUE_SECTOR);
    end else begin
      center = HUE_W'(5 * HUE_SECTOR);
    end
    dist_d = (hue_q >= center) ? DIST_W'(hue_q - center) : DIST_W'(center - hue_q);
    vs_d   = VS_W'(v_q) * VS_W'(s_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sector_q <= sector_d;
      dist_q   <= dist_d;
      vs_q     <= vs_d;
      v2_q     <= v_q;
      f2_q     <= f1_q;
    end
  end

  always_comb begin
    px_d   = PROD_W'(vs_q) * PROD_W'(dist_q);
    pz_d   = PROD_W'(vs_q) * PROD_W'(HUE_SECTOR);
    vone_d = (VW'(v2_q) << SCALE_BITS) * VW'(HUE_SECTOR);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      px_q      <= px_d;
      pz_q      <= pz_d;
      vone_q    <= vone_d;
      sector3_q <= sector_q;
      f3_q      <= f2_q;
    end
  end

  assign sector_o = sector3_q;
  assign px_o     = px_q;
  assign pz_o     = pz_q;
  assign vone_o   = vone_q;
  assign factor_o = f3_q;

endmodule

`default_nettype wire

/* rtl/hsvf_scale.sv */
// Channel stages: per-channel numerator, scale by the channel maximum with the
// power-of-two part of the divisor, then the exact divide by fifteen. Depends on hsvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvf_scale import hsvf_pkg::*; #(
  parameter int unsigned SCALE_BITS = 8
) (
  input  wire                                clk_i,
  input  stg_en_t                            en_i,
  input  sector_e                            sector_i,
  input  wire  [2*IN_W+DIST_W-1:0]           px_i,
  input  wire  [2*IN_W+DIST_W-1:0]           pz_i,
  input  wire  [IN_W+SCALE_BITS+DIST_W-1:0]  vone_i,
  input  wire  [IN_W-1:0]                    factor_i,
  output logic [CH_W-1:0]                    chan_o [NUM_CH],
  output logic [IN_W-1:0]                    factor_o
);

  localparam int unsigned PROD_W = 2 * IN_W + DIST_W;
  localparam int unsigned VW     = IN_W + SCALE_BITS + DIST_W;
  localparam int unsigned PW     = VW + CH_W;
  localparam int unsigned QSHIFT = 2 * SCALE_BITS + SECTOR_POW;

  logic [PROD_W-1:0] psel [NUM_CH];
  logic [VW-1:0]     w_d [NUM_CH];
  logic [VW-1:0]     w_q [NUM_CH];
  logic [QT_W-1:0]   t_d [NUM_CH];
  logic [QT_W-1:0]   t_q [NUM_CH];
  logic [QM_W-1:0]   q0 [NUM_CH];
  logic [QM_W-1:0]   rem [NUM_CH];
  logic [CH_W-1:0]   chan_d [NUM_CH];
  logic [CH_W-1:0]   chan_q [NUM_CH];
  logic [IN_W-1:0]   f4_q, f5_q, f6_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      case (pick(sector_i, 2'(c)))
        PICK_C:  psel[c] = '0;
        PICK_X:  psel[c] = px_i;
        default: psel[c] = pz_i;
      endcase
      w_d[c] = vone_i - VW'(psel[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      w_q  <= w_d;
      f4_q <= factor_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      t_d[c] = QT_W'((PW'(w_q[c]) * PW'(ch_max(2'(c)))) >> QSHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      t_q  <= t_d;
      f5_q <= f4_q;
    end
  end

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      q0[c]  = (QM_W'(t_q[c]) * QM_W'(RECIP_MUL)) >> RECIP_SHIFT;
      rem[c] = QM_W'(t_q[c]) - q0[c] * QM_W'(SECTOR_ODD);
      chan_d[c] = (rem[c] >= QM_W'(SECTOR_ODD)) ? CH_W'(q0[c] + QM_W'(1)) : CH_W'(q0[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      chan_q <= chan_d;
      f6_q   <= f5_q;
    end
  end

  assign chan_o   = chan_q;
  assign factor_o = f6_q;

endmodule

`default_nettype wire

/* rtl/hsvf_fade.sv */
// Fade stages: channel times factor, shift by the fixed-point scale, then
// saturate and pack both RGB565 words. Depends on hsvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvf_fade import hsvf_pkg::*; #(
  parameter int unsigned SCALE_BITS = 8
) (
  input  wire               clk_i,
  input  stg_en_t           en_i,
  input  wire  [CH_W-1:0]   chan_i [NUM_CH],
  input  wire  [IN_W-1:0]   factor_i,
  output logic [PIX_W-1:0]  pixel_color_o,
  output logic [PIX_W-1:0]  base_color_o
);

  localparam int unsigned FP_W = CH_W + IN_W;

  logic [FP_W-1:0]  prod_d [NUM_CH];
  logic [FP_W-1:0]  prod_q [NUM_CH];
  logic [CH_W-1:0]  chan7_q [NUM_CH];
  logic [FP_W-1:0]  sh_d [NUM_CH];
  logic [FP_W-1:0]  sh_q [NUM_CH];
  logic [CH_W-1:0]  chan8_q [NUM_CH];
  logic [CH_W-1:0]  fch [NUM_CH];
  logic [PIX_W-1:0] pixel_d, pixel_q, base_d, base_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_d[c] = FP_W'(chan_i[c]) * FP_W'(factor_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      prod_q  <= prod_d;
      chan7_q <= chan_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sh_d[c] = prod_q[c] >> SCALE_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      sh_q    <= sh_d;
      chan8_q <= chan7_q;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      fch[c] = (sh_q[c] > FP_W'(ch_max(2'(c)))) ? ch_max(2'(c)) : sh_q[c][CH_W-1:0];
    end
    pixel_d = pack565(fch[CH_R], fch[CH_G], fch[CH_B]);
    base_d  = pack565(chan8_q[CH_R], chan8_q[CH_G], chan8_q[CH_B]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pixel_q <= pixel_d;
      base_q  <= base_d;
    end
  end

  assign pixel_color_o = pixel_q;
  assign base_color_o  = base_q;

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb565_fade.sv */
// HSV to RGB565 converter with per-channel fade, nine register stages deep.
// Throughput: one beat per cycle while the output is ready; each stage
// advances when it is empty or its successor advances, so bubbles close up
// under output back-pressure.
// Reset clears only the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb565_fade import hsvf_pkg::*; #(
  parameter int unsigned SCALE_BITS = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [HUE_W-1:0]  hue_i,
  input  wire  [IN_W-1:0]   saturation_i,
  input  wire  [IN_W-1:0]   brightness_i,
  input  wire  [IN_W-1:0]   fade_factor_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [PIX_W-1:0]  pixel_color_o,
  output logic [PIX_W-1:0]  base_color_o
);

  localparam int unsigned PROD_W = 2 * IN_W + DIST_W;
  localparam int unsigned VW     = IN_W + SCALE_BITS + DIST_W;

  logic [PIPE_DEPTH-1:0] en;
  logic [PIPE_DEPTH-1:0] vld_d, vld_q;
  stg_en_t               en_front, en_scale, en_fade;

  sector_e               sector;
  logic [PROD_W-1:0]     px, pz;
  logic [VW-1:0]         vone;
  logic [IN_W-1:0]       factor_a, factor_b;
  logic [CH_W-1:0]       chan [NUM_CH];

  always_comb begin
    en[PIPE_DEPTH-1] = ~vld_q[PIPE_DEPTH-1] | out_ready_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_front = '{s0: en[0], s1: en[1], s2: en[2]};
  assign en_scale = '{s0: en[3], s1: en[4], s2: en[5]};
  assign en_fade  = '{s0: en[6], s1: en[7], s2: en[8]};

  hsvf_front #(
    .SCALE_BITS (SCALE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .en_i          (en_front),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .brightness_i  (brightness_i),
    .fade_factor_i (fade_factor_i),
    .sector_o      (sector),
    .px_o          (px),
    .pz_o          (pz),
    .vone_o        (vone),
    .factor_o      (factor_a)
  );

  hsvf_scale #(
    .SCALE_BITS (SCALE_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .en_i     (en_scale),
    .sector_i (sector),
    .px_i     (px),
    .pz_i     (pz),
    .vone_i   (vone),
    .factor_i (factor_a),
    .chan_o   (chan),
    .factor_o (factor_b)
  );

  hsvf_fade #(
    .SCALE_BITS (SCALE_BITS)
  ) u_fade (
    .clk_i         (clk_i),
    .en_i          (en_fade),
    .chan_i        (chan),
    .factor_i      (factor_b),
    .pixel_color_o (pixel_color_o),
    .base_color_o  (base_color_o)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  `ASSERT_IMPLIES(a_full_when_blocked, clk_i, rst_ni, !in_ready_o, (&vld_q) && !out_ready_i)
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0])
  `ASSERT_IMPLIES(a_black_stays_black, clk_i, rst_ni, out_valid_o && ~|base_color_o, ~|pixel_color_o)

endmodule

`default_nettype wire

/* tb/rgb565_fade_checker.sv */
// Checker for hsv_to_rgb565_fade: watches the input and output channels, predicts the
// faded and unfaded RGB565 colors of every input beat and compares them in order.
// Depends on hsvf_pkg for the field widths, the hue constants and the sector enum.
`timescale 1ns / 1ps

module rgb565_fade_checker import hsvf_pkg::*; #(
  parameter int unsigned SCALE_BITS = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_ready_i,
  input  wire [HUE_W-1:0]  hue_i,
  input  wire [IN_W-1:0]   saturation_i,
  input  wire [IN_W-1:0]   brightness_i,
  input  wire [IN_W-1:0]   fade_factor_i,
  input  wire              out_valid_i,
  input  wire              out_ready_i,
  input  wire [PIX_W-1:0]  pixel_color_i,
  input  wire [PIX_W-1:0]  base_color_i,
  output int               fail_count_o,
  output int               colors_owed_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] base;
  } colors_t;

  localparam longint unsigned ONE = 64'd1 << SCALE_BITS;
  localparam int RED_LSB = 11;
  localparam int GRN_LSB = 5;

  colors_t colors_due[$];
  colors_t want;
  int      mismatches = 0;

  function automatic longint unsigned clip(longint unsigned val, longint unsigned top);
    return (val > top) ? top : val;
  endfunction

  function automatic colors_t hsv_fade_colors(logic [HUE_W-1:0] hue, logic [IN_W-1:0] sat,
                                              logic [IN_W-1:0] bri, logic [IN_W-1:0] fade);
    longint unsigned h, s, v, f, span, pos, hue_gap, cn, xn, mn, rn, gn, bn;
    longint unsigned r, g, b, fr, fg, fb;
    sector_e         sec;
    colors_t         res;
    h = hue;
    if (h >= HUE_FULL) h = h - HUE_FULL;
    s = clip(sat, ONE);
    v = clip(bri, ONE);
    f = fade;
    span = ONE * ONE * HUE_SECTOR;
    sec = sector_e'(h / HUE_SECTOR);
    pos = h % (2 * HUE_SECTOR);
    hue_gap = (pos >= HUE_SECTOR) ? (pos - HUE_SECTOR) : (HUE_SECTOR - pos);
    cn = v * s * HUE_SECTOR;
    xn = v * s * (HUE_SECTOR - hue_gap);
    mn = v * ONE * HUE_SECTOR - cn;
    case (sec)
      SEC_RED_YEL: begin
        rn = cn; gn = xn; bn = 0;
      end
      SEC_YEL_GRN: begin
        rn = xn; gn = cn; bn = 0;
      end
      SEC_GRN_CYN: begin
        rn = 0; gn = cn; bn = xn;
      end
      SEC_CYN_BLU: begin
        rn = 0; gn = xn; bn = cn;
      end
      SEC_BLU_MAG: begin
        rn = xn; gn = 0; bn = cn;
      end
      default: begin
        rn = cn; gn = 0; bn = xn;
      end
    endcase
    r = clip((rn + mn) * R_MAX / span, R_MAX);
    g = clip((gn + mn) * G_MAX / span, G_MAX);
    b = clip((bn + mn) * B_MAX / span, B_MAX);
    fr = clip((r * f) >> SCALE_BITS, R_MAX);
    fg = clip((g * f) >> SCALE_BITS, G_MAX);
    fb = clip((b * f) >> SCALE_BITS, B_MAX);
    res.base = PIX_W'((r << RED_LSB) | (g << GRN_LSB) | b);
    res.pixel = PIX_W'((fr << RED_LSB) | (fg << GRN_LSB) | fb);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_due.delete();
      fail_count_o <= 0;
      colors_owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (colors_due.size() == 0) begin
          $error("unexpected color beat: pixel_color %h base_color %h",
                 pixel_color_i, base_color_i);
          mismatches++;
        end else begin
          want = colors_due.pop_front();
          if (pixel_color_i !== want.pixel) begin
            $error("pixel_color: expected %h, actual %h", want.pixel, pixel_color_i);
            mismatches++;
          end
          if (base_color_i !== want.base) begin
            $error("base_color: expected %h, actual %h", want.base, base_color_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        colors_due.push_back(hsv_fade_colors(hue_i, saturation_i, brightness_i,
                                             fade_factor_i));
      end
      fail_count_o <= mismatches;
      colors_owed_o <= colors_due.size();
    end
  end

endmodule

/* tb/tb_hsv_to_rgb565_fade.sv */
// Top of the hsv_to_rgb565_fade regression: drives directed and random HSV beats with
// random gaps and output stalls, and fails on checker mismatches or an idle watchdog.
// Depends on hsvf_pkg, the hsv_to_rgb565_fade RTL and rgb565_fade_checker.
`timescale 1ns / 1ps

module tb_hsv_to_rgb565_fade;
  import hsvf_pkg::*;

  localparam int RAND_PIXELS = 1330;
  localparam int MAX_WAIT    = 17;
  localparam int STALL_LIMIT = 1000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [HUE_W-1:0] hue = '0;
  logic [IN_W-1:0]  saturation = '0;
  logic [IN_W-1:0]  brightness = '0;
  logic [IN_W-1:0]  fade_factor = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] pixel_color;
  logic [PIX_W-1:0] base_color;
  int               fail_count;
  int               colors_owed;
  int               idle_cycles = 0;
  int               sender_calm = 0;
  int               receiver_calm = 0;
  int               stall_cycles;

  hsv_to_rgb565_fade uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .hue_i         (hue),
    .saturation_i  (saturation),
    .brightness_i  (brightness),
    .fade_factor_i (fade_factor),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_color_o (pixel_color),
    .base_color_o  (base_color)
  );

  rgb565_fade_checker colors_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .hue_i         (hue),
    .saturation_i  (saturation),
    .brightness_i  (brightness),
    .fade_factor_i (fade_factor),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_color_i (pixel_color),
    .base_color_i  (base_color),
    .fail_count_o  (fail_count),
    .colors_owed_o (colors_owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic draw_wait(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(30, 120);
      cycles = $urandom_range(0, 1) ? 0 : $urandom_range(0, MAX_WAIT);
    end
  endtask

  function automatic logic [HUE_W-1:0] random_hue();
    if ($urandom_range(0, 6) == 0) return HUE_W'($urandom_range(HUE_FULL, 32767));
    return HUE_W'($urandom_range(0, HUE_FULL - 1));
  endfunction

  function automatic logic [IN_W-1:0] random_unit();
    case ($urandom_range(0, 7))
      0:       return IN_W'($urandom_range(257, 511));
      1:       return $urandom_range(0, 1) ? 9'd0 : 9'd256;
      default: return IN_W'($urandom_range(0, 256));
    endcase
  endfunction

  task automatic drive_pixel(input logic [HUE_W-1:0] h, input logic [IN_W-1:0] s,
                             input logic [IN_W-1:0] v, input logic [IN_W-1:0] f);
    int gap;
    draw_wait(sender_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hue <= h;
    saturation <= s;
    brightness <= v;
    fade_factor <= f;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      draw_wait(receiver_calm, stall_cycles);
      if (stall_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (out_valid !== 1'b1);
      @(posedge clk);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("hsv_to_rgb565_fade regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_pixel(0, 256, 256, 256);
    drive_pixel(1920, 256, 256, 256);
    drive_pixel(3839, 256, 256, 256);
    drive_pixel(3840, 256, 256, 256);
    drive_pixel(7680, 256, 256, 256);
    drive_pixel(11520, 256, 256, 256);
    drive_pixel(15360, 256, 256, 256);
    drive_pixel(19200, 256, 256, 256);
    drive_pixel(23039, 256, 256, 256);
    drive_pixel(23040, 256, 256, 256);
    drive_pixel(32767, 256, 256, 256);
    drive_pixel(5000, 0, 256, 256);
    drive_pixel(5000, 256, 0, 256);
    drive_pixel(5000, 511, 511, 256);
    drive_pixel(5000, 257, 300, 256);
    drive_pixel(12000, 200, 256, 0);
    drive_pixel(12000, 200, 256, 511);
    drive_pixel(1000, 128, 256, 1);
    drive_pixel(20000, 256, 256, 384);
    drive_pixel(9999, 170, 200, 300);
    drive_pixel(0, 511, 511, 511);
    drive_pixel(0, 0, 0, 0);

    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i == RAND_PIXELS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (colors_owed != 0);
      end
      drive_pixel(random_hue(), random_unit(), random_unit(),
                  ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(0, 511)));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (colors_owed != 0);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("hsv_to_rgb565_fade regression: pass");
    end else begin
      $display("hsv_to_rgb565_fade regression: fail");
    end
    $finish;
  end

endmodule
